/* hdl/vna_pkg.sv */
`timescale 1ns / 1ps

package vna_pkg;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_TRI   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam int COORD_W = 16;
    localparam int POS_W   = 3 * COORD_W;
    localparam int INDEX_W = 10;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = 30;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int ROOT_W  = 64;
    localparam int LEN_W   = 31;
    localparam int FRAC_W  = 14;
    localparam int NUM_W   = MAG_W + FRAC_W + 1;
    localparam int DIV_STEPS = NUM_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CROSS_W-1:0] cross_t;

endpackage

/* hdl/vertex_normal_accumulator_unit.sv */
`timescale 1ns / 1ps
// vertex normal accumulator
// input channel (in_valid / in_stall) carries one beat per action: position
// write, triangle add or normal read. output channel (out_valid / out_stall)
// carries one beat per read: vertex index, unit normal in Q1.14, zero flag.
// one action is worked at a time; in_stall is high while it is in flight.
// a triangle's run time is set by the single read port of the position memory
// (three corner reads) and three read-modify-writes on the sum memory.
// read: magnitude prescale, then sum of squares on one multiplier, bitwise
// square root and three parallel restoring dividers. out-of-range or zero
// reads skip straight to the result.
// the result sits in an output register, so a new beat is taken while it
// waits; a read that finishes while the output is still stalled holds in its
// last state until the register frees up.
// reset clears control only; memory contents are undefined until written
// (a position write also clears that vertex's sum).
module vertex_normal_accumulator_unit #(
    parameter int VERTICES = 1024,
    parameter int SUM_BITS = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic [9:0]          index_a,
    input  logic [9:0]          index_b,
    input  logic [9:0]          index_c,
    input  logic signed [15:0]  pos_x,
    input  logic signed [15:0]  pos_y,
    input  logic signed [15:0]  pos_z,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [9:0]          vertex_index,
    output logic signed [15:0]  normal_x,
    output logic signed [15:0]  normal_y,
    output logic signed [15:0]  normal_z,
    output logic                zero_length
);

    localparam int IDX_W  = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int SUMS_W = 3 * SUM_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_WR, S_PA, S_PB, S_PC, S_PD, S_MUL, S_CRS,
        S_RMW_RD, S_RMW_WR, S_RD_REQ, S_RD_WAIT, S_SHIFT, S_SQ,
        S_ROOT, S_DINIT, S_DIV, S_FIN
    } state_t;

    state_t state_reg;

    logic [vna_pkg::POS_W-1:0] pos_mem [VERTICES];
    logic [SUMS_W-1:0]         sum_mem [VERTICES];
    logic [vna_pkg::POS_W-1:0] pos_q_reg;
    logic [SUMS_W-1:0]         sum_q_reg;

    logic [vna_pkg::INDEX_W-1:0] ia_reg, ib_reg, ic_reg;
    logic                        range_reg;
    vna_pkg::coord_t             px_reg, py_reg, pz_reg;

    vna_pkg::coord_t pa_reg [3];
    vna_pkg::coord_t pb_reg [3];
    vna_pkg::diff_t  u_reg [3];
    vna_pkg::diff_t  w_reg [3];
    vna_pkg::prod_t  prod_reg [6];
    vna_pkg::cross_t crs_reg [3];
    logic [1:0]      corner_reg;

    logic [SUM_BITS-1:0]       mag_reg [3];
    logic                      sign_reg [3];
    logic [1:0]                cnt_reg;
    logic [vna_pkg::SQ_W-1:0]  mul_reg;
    logic [vna_pkg::ROOT_W-1:0] n_reg, res_reg, bit_reg;
    logic [vna_pkg::LEN_W-1:0] len_reg;
    logic [vna_pkg::LEN_W-1:0] rem_reg [3];
    logic [vna_pkg::NUM_W-1:0] num_reg [3];
    logic [5:0]                step_reg;
    logic                      zero_reg;

    logic                      out_valid_reg;
    logic [9:0]                vidx_reg;
    logic signed [15:0]        nx_reg, ny_reg, nz_reg;
    logic                      zl_reg;

    logic                      in_fire;
    logic                      out_free;
    logic                      pos_re, sum_re, pos_we, sum_we;
    logic [IDX_W-1:0]          pos_raddr, sum_raddr, waddr;
    logic [SUMS_W-1:0]         sum_wdata;
    logic signed [SUM_BITS-1:0] sum_lane [3];
    logic signed [SUM_BITS-1:0] sum_new [3];
    vna_pkg::coord_t           q_lane [3];
    logic [vna_pkg::INDEX_W-1:0] corner_idx;
    logic [SUM_BITS-1:0]       mag_or;
    logic [vna_pkg::ROOT_W-1:0] trial;
    logic [vna_pkg::LEN_W-1:0] rem_next [3];
    logic [vna_pkg::NUM_W-1:0] num_next [3];
    logic [vna_pkg::LEN_W:0]   rem_try [3];

    function automatic logic signed [SUM_BITS-1:0] sat_add(
        input logic signed [SUM_BITS-1:0] s,
        input vna_pkg::cross_t c
    );
        logic signed [SUM_BITS:0] t;
        t = {s[SUM_BITS-1], s} + {{(SUM_BITS + 1 - vna_pkg::CROSS_W){c[vna_pkg::CROSS_W-1]}}, c};
        if (t[SUM_BITS] != t[SUM_BITS-1])
            sat_add = t[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
        else
            sat_add = t[SUM_BITS-1:0];
    endfunction

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign vertex_index = vidx_reg;
    assign normal_x     = nx_reg;
    assign normal_y     = ny_reg;
    assign normal_z     = nz_reg;
    assign zero_length  = zl_reg;

    assign q_lane[0] = pos_q_reg[3*vna_pkg::COORD_W-1:2*vna_pkg::COORD_W];
    assign q_lane[1] = pos_q_reg[2*vna_pkg::COORD_W-1:vna_pkg::COORD_W];
    assign q_lane[2] = pos_q_reg[vna_pkg::COORD_W-1:0];

    assign sum_lane[0] = sum_q_reg[3*SUM_BITS-1:2*SUM_BITS];
    assign sum_lane[1] = sum_q_reg[2*SUM_BITS-1:SUM_BITS];
    assign sum_lane[2] = sum_q_reg[SUM_BITS-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_new[i] = sat_add(sum_lane[i], crs_reg[i]);
        end
    end

    always_comb
    begin
        unique case (corner_reg)
            2'd0:    corner_idx = ia_reg;
            2'd1:    corner_idx = ib_reg;
            default: corner_idx = ic_reg;
        endcase
    end

    // memory port control
    always_comb
    begin
        pos_re    = 1'b0;
        sum_re    = 1'b0;
        pos_we    = 1'b0;
        sum_we    = 1'b0;
        pos_raddr = IDX_W'(ia_reg);
        sum_raddr = IDX_W'(ia_reg);
        waddr     = IDX_W'(ia_reg);
        sum_wdata = '0;
        unique case (state_reg)
            S_WR:
            begin
                pos_we = range_reg;
                sum_we = range_reg;
            end
            S_PA:
            begin
                pos_re = 1'b1;
            end
            S_PB:
            begin
                pos_re    = 1'b1;
                pos_raddr = IDX_W'(ib_reg);
            end
            S_PC:
            begin
                pos_re    = 1'b1;
                pos_raddr = IDX_W'(ic_reg);
            end
            S_RMW_RD:
            begin
                sum_re    = 1'b1;
                sum_raddr = IDX_W'(corner_idx);
            end
            S_RMW_WR:
            begin
                sum_we    = 1'b1;
                waddr     = IDX_W'(corner_idx);
                sum_wdata = {sum_new[0], sum_new[1], sum_new[2]};
            end
            S_RD_REQ:
            begin
                sum_re = range_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[waddr] <= {px_reg, py_reg, pz_reg};
        if (pos_re)
            pos_q_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
            sum_mem[waddr] <= sum_wdata;
        if (sum_re)
            sum_q_reg <= sum_mem[sum_raddr];
    end

    assign mag_or = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign trial  = res_reg + bit_reg;

    // restoring divider lanes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_try[i] = {rem_reg[i], num_reg[i][vna_pkg::NUM_W-1]};
            if (rem_try[i] >= {1'b0, len_reg})
            begin
                rem_next[i] = vna_pkg::LEN_W'(rem_try[i] - {1'b0, len_reg});
                num_next[i] = {num_reg[i][vna_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = rem_try[i][vna_pkg::LEN_W-1:0];
                num_next[i] = {num_reg[i][vna_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        ia_reg    <= index_a;
                        ib_reg    <= index_b;
                        ic_reg    <= index_c;
                        px_reg    <= pos_x;
                        py_reg    <= pos_y;
                        pz_reg    <= pos_z;
                        unique case (action)
                            vna_pkg::ACT_WRITE:
                            begin
                                range_reg <= (32'(index_a) < VERTICES);
                                state_reg <= S_WR;
                            end
                            vna_pkg::ACT_TRI:
                            begin
                                range_reg <= (32'(index_a) < VERTICES)
                                             && (32'(index_b) < VERTICES)
                                             && (32'(index_c) < VERTICES);
                                state_reg <= S_PA;
                            end
                            vna_pkg::ACT_READ:
                            begin
                                range_reg <= (32'(index_a) < VERTICES);
                                state_reg <= S_RD_REQ;
                            end
                            default:
                            begin
                                range_reg <= 1'b0;
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_WR:
                begin
                    state_reg <= S_IDLE;
                end
                S_PA:
                begin
                    state_reg <= range_reg ? S_PB : S_IDLE;
                end
                S_PB:
                begin
                    pa_reg    <= q_lane;
                    state_reg <= S_PC;
                end
                S_PC:
                begin
                    pb_reg    <= q_lane;
                    state_reg <= S_PD;
                end
                S_PD:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        u_reg[i] <= vna_pkg::DIFF_W'(pb_reg[i]) - vna_pkg::DIFF_W'(pa_reg[i]);
                        w_reg[i] <= vna_pkg::DIFF_W'(q_lane[i]) - vna_pkg::DIFF_W'(pa_reg[i]);
                    end
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg[0] <= u_reg[1] * w_reg[2];
                    prod_reg[1] <= u_reg[2] * w_reg[1];
                    prod_reg[2] <= u_reg[2] * w_reg[0];
                    prod_reg[3] <= u_reg[0] * w_reg[2];
                    prod_reg[4] <= u_reg[0] * w_reg[1];
                    prod_reg[5] <= u_reg[1] * w_reg[0];
                    state_reg   <= S_CRS;
                end
                S_CRS:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        crs_reg[i] <= vna_pkg::CROSS_W'(prod_reg[2*i])
                                      - vna_pkg::CROSS_W'(prod_reg[2*i+1]);
                    end
                    corner_reg <= 2'd0;
                    state_reg  <= S_RMW_RD;
                end
                S_RMW_RD:
                begin
                    state_reg <= S_RMW_WR;
                end
                S_RMW_WR:
                begin
                    corner_reg <= corner_reg + 2'd1;
                    state_reg  <= (corner_reg == 2'd2) ? S_IDLE : S_RMW_RD;
                end
                S_RD_REQ:
                begin
                    zero_reg  <= 1'b1;
                    state_reg <= range_reg ? S_RD_WAIT : S_FIN;
                end
                S_RD_WAIT:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sign_reg[i] <= sum_lane[i][SUM_BITS-1];
                        mag_reg[i]  <= sum_lane[i][SUM_BITS-1] ? SUM_BITS'(-sum_lane[i])
                                                               : SUM_BITS'(sum_lane[i]);
                    end
                    state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    if (mag_or == '0)
                        state_reg <= S_FIN;
                    else if (|mag_or[SUM_BITS-1:vna_pkg::MAG_W])
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            mag_reg[i] <= mag_reg[i] >> 1;
                        end
                    end
                    else
                    begin
                        zero_reg  <= 1'b0;
                        cnt_reg   <= 2'd0;
                        n_reg     <= '0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (cnt_reg != 2'd3)
                        mul_reg <= mag_reg[cnt_reg][vna_pkg::MAG_W-1:0]
                                   * mag_reg[cnt_reg][vna_pkg::MAG_W-1:0];
                    if (cnt_reg != 2'd0)
                        n_reg <= n_reg + vna_pkg::ROOT_W'(mul_reg);
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        res_reg   <= '0;
                        bit_reg   <= vna_pkg::ROOT_W'(1) << (vna_pkg::ROOT_W - 2);
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if (n_reg >= trial)
                    begin
                        n_reg   <= n_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                        res_reg <= res_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                        state_reg <= S_DINIT;
                end
                S_DINIT:
                begin
                    len_reg <= (res_reg == '0) ? vna_pkg::LEN_W'(1)
                                               : res_reg[vna_pkg::LEN_W-1:0];
                    for (int i = 0; i < 3; i++)
                    begin
                        rem_reg[i] <= '0;
                        num_reg[i] <= {1'b0, mag_reg[i][vna_pkg::MAG_W-1:0],
                                       {vna_pkg::FRAC_W{1'b0}}}
                                      + vna_pkg::NUM_W'(((res_reg == '0) ? vna_pkg::LEN_W'(1)
                                                        : res_reg[vna_pkg::LEN_W-1:0]) >> 1);
                    end
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= rem_next;
                    num_reg  <= num_next;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(vna_pkg::DIV_STEPS - 1))
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        vidx_reg      <= ia_reg;
                        zl_reg        <= zero_reg;
                        if (zero_reg)
                        begin
                            nx_reg <= '0;
                            ny_reg <= '0;
                            nz_reg <= '0;
                        end
                        else
                        begin
                            nx_reg <= sign_reg[0] ? -$signed(num_reg[0][15:0]) : $signed(num_reg[0][15:0]);
                            ny_reg <= sign_reg[1] ? -$signed(num_reg[1][15:0]) : $signed(num_reg[1][15:0]);
                            nz_reg <= sign_reg[2] ? -$signed(num_reg[2][15:0]) : $signed(num_reg[2][15:0]);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/vna_checker.sv */
`timescale 1ns / 1ps

module vna_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] normal_x,
    input logic signed [15:0] normal_y,
    input logic signed [15:0] normal_z,
    input logic               zero_length
);

    // stalled beat stays
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped under stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(normal_x) && $stable(normal_y)
                                   && $stable(normal_z) && $stable(zero_length))
        else $error("output beat changed under stall");

    // zero flag means zero vector
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_length |-> normal_x == 16'sd0 && normal_y == 16'sd0
                                     && normal_z == 16'sd0)
        else $error("zero flag with nonzero normal");

    // unit normal is nonzero and within Q1.14 range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_length |->
            (normal_x != 16'sd0 || normal_y != 16'sd0 || normal_z != 16'sd0)
            && normal_x <= 16'sd16384 && normal_x >= -16'sd16384
            && normal_y <= 16'sd16384 && normal_y >= -16'sd16384
            && normal_z <= 16'sd16384 && normal_z >= -16'sd16384)
        else $error("normal out of range");

endmodule

bind vertex_normal_accumulator_unit vna_checker u_vna_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .zero_length (zero_length)
);

/* test/tb_vertex_normal_accumulator_unit.sv */
`timescale 1ns / 1ps

module tb_vertex_normal_accumulator_unit;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int NVERT = 1024;
    localparam int SAT_TRIS = 24;
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]         act;
        logic [9:0]         a;
        logic [9:0]         b;
        logic [9:0]         c;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } action_t;

    typedef struct packed {
        logic [9:0]         vtx;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               zl;
    } normal_t;

    class normal_scoreboard;
        logic signed [15:0] px [NVERT];
        logic signed [15:0] py [NVERT];
        logic signed [15:0] pz [NVERT];
        longint sum_x [NVERT];
        longint sum_y [NVERT];
        longint sum_z [NVERT];
        normal_t due [$];

        function longint sat_add(longint s, longint c);
            longint hi;
            longint lo;
            hi = (64'sd1 <<< 47) - 1;
            lo = -hi - 1;
            if (c > 0 && s > hi - c)
            begin
                return hi;
            end
            if (c < 0 && s < lo - c)
            begin
                return lo;
            end
            return s + c;
        endfunction

        function longint unsigned int_root(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
            begin
                bitv = bitv >> 2;
            end
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function logic signed [15:0] unit_comp(longint s, longint unsigned m,
                                               longint unsigned len);
            longint unsigned q;
            q = (m * 16384 + len / 2) / len;
            return (s < 0) ? -q[15:0] : q[15:0];
        endfunction

        function void note_action(action_t it);
            longint ux, uy, uz, wx, wy, wz, cx, cy, cz;
            longint unsigned mx, my, mz, big, len;
            int corner [3];
            normal_t r;
            case (it.act)
                vna_pkg::ACT_WRITE:
                begin
                    px[it.a] = it.x;
                    py[it.a] = it.y;
                    pz[it.a] = it.z;
                    sum_x[it.a] = 0;
                    sum_y[it.a] = 0;
                    sum_z[it.a] = 0;
                end
                vna_pkg::ACT_TRI:
                begin
                    ux = longint'(px[it.b]) - longint'(px[it.a]);
                    uy = longint'(py[it.b]) - longint'(py[it.a]);
                    uz = longint'(pz[it.b]) - longint'(pz[it.a]);
                    wx = longint'(px[it.c]) - longint'(px[it.a]);
                    wy = longint'(py[it.c]) - longint'(py[it.a]);
                    wz = longint'(pz[it.c]) - longint'(pz[it.a]);
                    cx = uy * wz - uz * wy;
                    cy = uz * wx - ux * wz;
                    cz = ux * wy - uy * wx;
                    corner[0] = it.a;
                    corner[1] = it.b;
                    corner[2] = it.c;
                    foreach (corner[k])
                    begin
                        sum_x[corner[k]] = sat_add(sum_x[corner[k]], cx);
                        sum_y[corner[k]] = sat_add(sum_y[corner[k]], cy);
                        sum_z[corner[k]] = sat_add(sum_z[corner[k]], cz);
                    end
                end
                vna_pkg::ACT_READ:
                begin
                    r.vtx = it.a;
                    mx = (sum_x[it.a] < 0) ? -sum_x[it.a] : sum_x[it.a];
                    my = (sum_y[it.a] < 0) ? -sum_y[it.a] : sum_y[it.a];
                    mz = (sum_z[it.a] < 0) ? -sum_z[it.a] : sum_z[it.a];
                    if ((mx | my | mz) == 0)
                    begin
                        r.nx = 0;
                        r.ny = 0;
                        r.nz = 0;
                        r.zl = 1'b1;
                    end
                    else
                    begin
                        big = mx;
                        if (my > big)
                        begin
                            big = my;
                        end
                        if (mz > big)
                        begin
                            big = mz;
                        end
                        while (big >= (64'd1 << 30))
                        begin
                            big = big >> 1;
                            mx = mx >> 1;
                            my = my >> 1;
                            mz = mz >> 1;
                        end
                        len = int_root(mx * mx + my * my + mz * mz);
                        if (len == 0)
                        begin
                            len = 1;
                        end
                        r.nx = unit_comp(sum_x[it.a], mx, len);
                        r.ny = unit_comp(sum_y[it.a], my, len);
                        r.nz = unit_comp(sum_z[it.a], mz, len);
                        r.zl = 1'b0;
                    end
                    due = {due, r};
                end
                default:
                begin
                end
            endcase
        endfunction

        // empty string when the beat matches
        function string check_normal(normal_t got);
            normal_t e;
            if (due.size() == 0)
            begin
                return $sformatf("unexpected normal beat for vertex %0d", got.vtx);
            end
            e = due.pop_front();
            if (got !== e)
            begin
                return $sformatf("vertex %0d/%0d: got %0d %0d %0d z%0b, want %0d %0d %0d z%0b",
                    got.vtx, e.vtx, got.nx, got.ny, got.nz, got.zl,
                    e.nx, e.ny, e.nz, e.zl);
            end
            return "";
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         action;
    logic [9:0]         index_a;
    logic [9:0]         index_b;
    logic [9:0]         index_c;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic               out_valid;
    logic               out_stall;
    logic [9:0]         vertex_index;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               zero_length;

    vertex_normal_accumulator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .index_a      (index_a),
        .index_b      (index_b),
        .index_c      (index_c),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .vertex_index (vertex_index),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z),
        .zero_length  (zero_length)
    );

    normal_scoreboard sb = new();
    action_t plan [$];
    action_t driven;
    bit  known [NVERT];
    int  known_list [$];
    int  next_beat = 0;
    int  sat_start = 0;
    int  burst_left = 1;
    int  gap_left = 0;
    int  stall_mode = 0;
    int  stall_span = 0;
    int  idle_cycles = 0;
    int  errors = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    task automatic report(input string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    task automatic add_write(input int v, input int x, input int y, input int z);
        action_t it;
        it = '{vna_pkg::ACT_WRITE, v[9:0], 10'($urandom), 10'($urandom),
               x[15:0], y[15:0], z[15:0]};
        plan = {plan, it};
        if (!known[v])
        begin
            known[v] = 1'b1;
            known_list = {known_list, v};
        end
    endtask

    task automatic add_other(input logic [1:0] act, input int a, input int b, input int c);
        action_t it;
        it = '{act, a[9:0], b[9:0], c[9:0], 16'($urandom), 16'($urandom), 16'($urandom)};
        plan = {plan, it};
    endtask

    function automatic int pick_known();
        return known_list[$urandom_range(0, known_list.size() - 1)];
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 3))
            0: return $signed(16'($urandom_range(0, 64))) - 32;
            1: return $urandom_range(0, 1) ? 32767 : -32768;
            default: return $signed(16'($urandom));
        endcase
    endfunction

    task automatic build_plan();
        int r;
        // directed: extremes, zero sums, degenerate and repeated corners, unused action
        add_write(0, 32767, 32767, 32767);
        add_write(1, -32768, -32768, -32768);
        add_write(2, 0, 0, 0);
        add_write(1023, -32768, 32767, 0);
        add_write(512, 32767, -32768, 32767);
        add_other(vna_pkg::ACT_READ, 2, 0, 0);
        add_other(vna_pkg::ACT_TRI, 0, 1, 2);
        add_other(vna_pkg::ACT_TRI, 0, 0, 1);
        add_other(vna_pkg::ACT_TRI, 1023, 1023, 1023);
        add_other(vna_pkg::ACT_READ, 0, 0, 0);
        add_other(vna_pkg::ACT_TRI, 1, 1023, 512);
        add_other(vna_pkg::ACT_TRI, 0, 512, 1023);
        add_other(vna_pkg::ACT_READ, 1, 0, 0);
        add_other(vna_pkg::ACT_READ, 1023, 0, 0);
        add_other(vna_pkg::ACT_READ, 512, 0, 0);
        add_other(ACT_UNUSED, 1023, 1023, 1023);
        add_write(512, 1, 2, 3);
        add_other(vna_pkg::ACT_READ, 512, 0, 0);
        add_other(vna_pkg::ACT_TRI, 2, 0, 1023);
        add_other(vna_pkg::ACT_READ, 2, 0, 0);
        for (int i = 0; i < 1300; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 22)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    add_write($urandom_range(0, NVERT - 1), rand_coord(), rand_coord(),
                              rand_coord());
                end
                else
                begin
                    add_write($urandom_range(0, 47) * 21, rand_coord(), rand_coord(),
                              rand_coord());
                end
            end
            else if (r < 70)
            begin
                add_other(vna_pkg::ACT_TRI, pick_known(), pick_known(), pick_known());
            end
            else if (r < 95)
            begin
                add_other(vna_pkg::ACT_READ, pick_known(), 0, 0);
            end
            else
            begin
                add_other(ACT_UNUSED, $urandom, $urandom, $urandom);
            end
        end
        // repeat one large triangle back to back to grow the sums
        sat_start = plan.size();
        add_write(100, -32768, -32768, 5);
        add_write(101, 32767, -32768, -7);
        add_write(102, -32768, 32767, 9);
        for (int i = 0; i < SAT_TRIS; i++)
        begin
            add_other(vna_pkg::ACT_TRI, 100, 101, 102);
        end
        add_other(vna_pkg::ACT_READ, 100, 0, 0);
        add_other(vna_pkg::ACT_READ, 101, 0, 0);
        add_other(vna_pkg::ACT_READ, 102, 0, 0);
    endtask

    // input side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action   <= vna_pkg::ACT_WRITE;
            index_a  <= '0;
            index_b  <= '0;
            index_c  <= '0;
            pos_x    <= '0;
            pos_y    <= '0;
            pos_z    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                sb.note_action(driven);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0 && next_beat < sat_start)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (next_beat < plan.size())
                begin
                    driven = plan[next_beat];
                    next_beat++;
                    in_valid <= 1'b1;
                    action   <= driven.act;
                    index_a  <= driven.a;
                    index_b  <= driven.b;
                    index_c  <= driven.c;
                    pos_x    <= driven.x;
                    pos_y    <= driven.y;
                    pos_z    <= driven.z;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: stall modes of random length
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                string msg;
                msg = sb.check_normal({vertex_index, normal_x, normal_y, normal_z, zero_length});
                if (msg != "")
                begin
                    report(msg);
                end
            end
            if (stall_span <= 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_span = $urandom_range(20, 300);
            end
            stall_span--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= 1'($urandom_range(0, 1));
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        build_plan();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (next_beat < plan.size() || in_valid)
        begin
            @(posedge clk);
        end
        while (sb.pending() > 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/vna_pkg.sv
hdl/vertex_normal_accumulator_unit.sv
hdl/vna_checker.sv
test/tb_vertex_normal_accumulator_unit.sv
